@@ hdl/rfhc_pkg.sv @@
// Shared types and constants for the radio frame header classifier.
// No dependencies.
`timescale 1ns / 1ps
package rfhc_pkg;
  localparam int unsigned CNT_W         = 48;
  localparam int unsigned NUM_SRC       = 16;
  localparam int unsigned SRC_W         = 4;
  localparam int unsigned FBYTES_W      = 13;
  localparam int unsigned SPF_SHIFT     = 12;
  localparam logic [31:0] SYNC_VALUE    = 32'h5CDEC0DE;
  localparam logic [12:0] HDR_BYTES     = 13'd32;
  localparam logic [12:0] MAX_FRAME_B   = 13'd4128;

  localparam logic [2:0] REG_SRC_COUNT  = 3'd0;
  localparam logic [2:0] REG_SRC_OFFSET = 3'd1;
  localparam logic [2:0] REG_WIN_START  = 3'd2;
  localparam logic [2:0] REG_SEQ_PER_BUF = 3'd3;
  localparam logic [2:0] REG_BUF_COUNT  = 3'd4;

  typedef enum logic [1:0] {
    V_INVALID = 2'd0,
    V_LATE    = 2'd1,
    V_ACCEPT  = 2'd2,
    V_BEYOND  = 2'd3
  } verdict_t;

  typedef struct packed {
    logic                 en;
    verdict_t             cls;
    logic [SRC_W-1:0]     src;
    logic [FBYTES_W-1:0]  nbytes;
  } cnt_upd_t;
endpackage

@@ hdl/rfhc_div.sv @@
// Bit-serial restoring divider: 64-bit dividend by 16-bit divisor, one bit per cycle.
// Depends on nothing beyond the timescale.
`timescale 1ns / 1ps
module rfhc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic        run_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] q_r;
  logic [15:0] dvs_r;
  logic [16:0] rem_r;
  logic [16:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r[15:0], q_r[63]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '1;
      end else if (run_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      q_r   <= {q_r[62:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

@@ hdl/rfhc_counters.sv @@
// Global and per-source frame and byte counters, 48-bit wrapping.
// Depends on rfhc_pkg.
`timescale 1ns / 1ps
module rfhc_counters
  import rfhc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cnt_upd_t         upd,
  output logic [CNT_W-1:0] class_count
);
  logic [CNT_W-1:0] gcnt_r  [3];
  logic [CNT_W-1:0] gbyte_r [3];
  logic [CNT_W-1:0] slc_r   [NUM_SRC];
  logic [CNT_W-1:0] slb_r   [NUM_SRC];
  logic [CNT_W-1:0] svc_r   [NUM_SRC];
  logic [CNT_W-1:0] svb_r   [NUM_SRC];
  logic [CNT_W-1:0] add_b;
  logic [1:0]       gi;

  assign add_b = {{(CNT_W-FBYTES_W){1'b0}}, upd.nbytes};
  assign gi    = (upd.cls == V_BEYOND) ? 2'd0 : upd.cls;
  assign class_count = (upd.cls == V_BEYOND) ? '0 : gcnt_r[gi] + 48'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        gcnt_r[i]  <= '0;
        gbyte_r[i] <= '0;
      end
      for (int i = 0; i < NUM_SRC; i++) begin
        slc_r[i] <= '0;
        slb_r[i] <= '0;
        svc_r[i] <= '0;
        svb_r[i] <= '0;
      end
    end else if (upd.en && upd.cls != V_BEYOND) begin
      gcnt_r[gi]  <= gcnt_r[gi] + 48'd1;
      gbyte_r[gi] <= gbyte_r[gi] + add_b;
      if (upd.cls == V_LATE) begin
        slc_r[upd.src] <= slc_r[upd.src] + 48'd1;
        slb_r[upd.src] <= slb_r[upd.src] + add_b;
      end
      if (upd.cls == V_ACCEPT) begin
        svc_r[upd.src] <= svc_r[upd.src] + 48'd1;
        svb_r[upd.src] <= svb_r[upd.src] + add_b;
      end
    end
  end
endmodule

@@ hdl/radio_frame_header_classifier.sv @@
// Top level: header checks, serial sequence divide, window placement, output register.
// Depends on rfhc_pkg, rfhc_div, rfhc_counters.
//
// Channel | Direction | Handshake          | Payload
// in_     | request   | in_valid/in_stall  | sync_pattern .. frame_bytes
// out_    | result    | out_valid/out_stall| verdict .. class_count
// cfg     | APB write | psel/penable/pready| paddr (8*i), pwdata/prdata 64
//
// A valid header's result is loaded after the 64 steps of the bit-serial divider and
// the window and offset math in S_WIN1, S_WIN2, S_MUL1 and S_MUL2. An invalid one
// goes straight to S_DONE. Either waits in S_DONE while the output register holds a
// stalled result. One request is in work at a time; the next is taken in the cycle
// after the result is loaded, even while it is stalled. Reset is synchronous and
// clears control state and all counters.
`timescale 1ns / 1ps
module radio_frame_header_classifier
  import rfhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sync_pattern,
  input  logic [7:0]  in_frame_id,
  input  logic [15:0] in_decimation,
  input  logic [15:0] in_time_offset,
  input  logic [63:0] in_raw_time_tag,
  input  logic [31:0] in_tuning_word,
  input  logic [12:0] in_frame_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_verdict,
  output logic [3:0]  out_source_index,
  output logic [63:0] out_sequence_res,
  output logic [63:0] out_corr_tag,
  output logic [30:0] out_tuning,
  output logic        out_buffer_index,
  output logic [31:0] out_element_offset,
  output logic [12:0] out_payload_bytes,
  output logic [47:0] out_class_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_WIN1, S_WIN2, S_MUL1, S_MUL2, S_DONE
  } state_t;

  state_t      state_r;
  logic [4:0]  src_cnt_r;
  logic [3:0]  src_off_r;
  logic [63:0] win_start_r;
  logic [15:0] spb_r;
  logic [1:0]  buf_cnt_r;

  logic        ok_r;
  logic [3:0]  src_r;
  logic [63:0] tt_r, seq_r, d_r, end_r;
  logic [30:0] tune_r;
  logic [12:0] fb_r, pay_r;
  logic        late_r, beyond_r, idx_r;
  logic [15:0] within_r;
  logic [20:0] p1_r;
  logic [31:0] off_r;

  logic        in_fire, out_load, wr;
  logic [6:0]  src_s;
  logic        ok;
  logic        div_done;
  logic [63:0] quot;
  logic [16:0] span, d17;
  logic        idx_c;
  logic [33:0] p2;
  logic [63:0] wnd_gap;
  verdict_t    verd;
  cnt_upd_t    upd;
  logic [47:0] cls_cnt;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && !(out_valid && out_stall);

  assign src_s = {3'b0, in_frame_id[5:3], in_frame_id[7]} - 7'd2 - {3'b0, src_off_r};

  assign ok = in_frame_bytes >= HDR_BYTES && in_frame_bytes <= MAX_FRAME_B &&
              in_sync_pattern == SYNC_VALUE && in_decimation != '0 &&
              !in_tuning_word[31] && !src_s[6] &&
              src_s[5:0] < {1'b0, src_cnt_r} && src_s[5:0] < 6'(NUM_SRC);

  rfhc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire && ok),
    .dividend(in_raw_time_tag - {48'b0, in_time_offset}),
    .divisor (in_decimation),
    .done    (div_done),
    .quotient(quot)
  );

  assign span = (buf_cnt_r == 2'd0) ? 17'd0 :
                (buf_cnt_r == 2'd1) ? {1'b0, spb_r} : {spb_r, 1'b0};
  assign d17     = d_r[16:0];
  assign idx_c   = d17 >= {1'b0, spb_r};
  assign p2      = p1_r * pay_r;
  assign wnd_gap = seq_r - end_r;

  always_comb begin
    if (!ok_r)         verd = V_INVALID;
    else if (beyond_r) verd = V_BEYOND;
    else if (late_r)   verd = V_LATE;
    else               verd = V_ACCEPT;
  end

  assign upd.en     = out_load;
  assign upd.cls    = verd;
  assign upd.src    = src_r;
  assign upd.nbytes = ok_r ? pay_r : fb_r;

  rfhc_counters u_cnt (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .class_count(cls_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r   <= 5'd4;
      src_off_r   <= '0;
      win_start_r <= '0;
      spb_r       <= 16'd1;
      buf_cnt_r   <= '0;
    end else if (wr) begin
      unique case (paddr[5:3])
        REG_SRC_COUNT:   src_cnt_r   <= pwdata[4:0];
        REG_SRC_OFFSET:  src_off_r   <= pwdata[3:0];
        REG_WIN_START:   win_start_r <= pwdata;
        REG_SEQ_PER_BUF: spb_r       <= pwdata[15:0];
        REG_BUF_COUNT:   buf_cnt_r   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_SRC_COUNT:   prdata = {59'b0, src_cnt_r};
      REG_SRC_OFFSET:  prdata = {60'b0, src_off_r};
      REG_WIN_START:   prdata = win_start_r;
      REG_SEQ_PER_BUF: prdata = {48'b0, spb_r};
      REG_BUF_COUNT:   prdata = {62'b0, buf_cnt_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_fire) state_r <= ok ? S_DIV : S_DONE;
        S_DIV:  if (div_done) state_r <= S_WIN1;
        S_WIN1: state_r <= S_WIN2;
        S_WIN2: state_r <= S_MUL1;
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_DONE;
        S_DONE: if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ok_r   <= ok;
      src_r  <= src_s[3:0];
      tt_r   <= in_raw_time_tag - {48'b0, in_time_offset};
      tune_r <= in_tuning_word[30:0];
      fb_r   <= in_frame_bytes;
      pay_r  <= in_frame_bytes - HDR_BYTES;
    end
    if (div_done) seq_r <= {{SPF_SHIFT{1'b0}}, quot[63:SPF_SHIFT]};
    if (state_r == S_WIN1) begin
      d_r   <= seq_r - win_start_r;
      end_r <= win_start_r + {47'b0, span};
    end
    if (state_r == S_WIN2) begin
      beyond_r <= !wnd_gap[63];
      late_r   <= d_r[63];
      idx_r    <= idx_c;
      within_r <= 16'(d17 - (idx_c ? {1'b0, spb_r} : 17'd0));
    end
    if (state_r == S_MUL1) p1_r <= within_r * src_cnt_r;
    if (state_r == S_MUL2) off_r <= (p2[33:32] != 2'b0) ? 32'hFFFF_FFFF : p2[31:0];
    if (out_load) begin
      out_verdict        <= verd;
      out_class_count    <= cls_cnt;
      out_source_index   <= ok_r ? src_r : '0;
      out_sequence_res   <= ok_r ? seq_r : '0;
      out_corr_tag       <= ok_r ? tt_r : '0;
      out_payload_bytes  <= ok_r ? pay_r : '0;
      out_tuning         <= (verd == V_ACCEPT) ? tune_r : '0;
      out_buffer_index   <= (verd == V_ACCEPT) ? idx_r : 1'b0;
      out_element_offset <= (verd == V_ACCEPT) ? off_r : '0;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE) else $error("request accepted but block idle");
  a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("divider finished outside divide phase");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == V_INVALID |-> out_sequence_res == '0 && out_source_index == '0)
    else $error("invalid result carries data");
  a_beyond_nocount: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == V_BEYOND |-> out_class_count == '0)
    else $error("beyond-window result carries a count");
`endif
endmodule

@@ tb/tb_radio_frame_header_classifier.sv @@
// Self-checking testbench for radio_frame_header_classifier: directed and random headers,
// APB register settings, random gaps on both channels. Depends on rfhc_pkg and the block.
`timescale 1ns / 1ps
module tb_radio_frame_header_classifier;
  import rfhc_pkg::*;

  typedef struct {
    logic [31:0] sync;
    logic [7:0]  fid;
    logic [15:0] dec;
    logic [15:0] toff;
    logic [63:0] raw;
    logic [31:0] tw;
    logic [12:0] fb;
  } header_t;

  typedef struct {
    verdict_t    verdict;
    logic [3:0]  src;
    logic [63:0] seq;
    logic [63:0] tt;
    logic [30:0] tuning;
    logic        bidx;
    logic [31:0] eoff;
    logic [12:0] pay;
    logic [47:0] cnt;
  } verdict_rec_t;

  class frame_scoreboard;
    verdict_rec_t pending[$];
    int errors = 0;
    logic [4:0]  src_count = 5'd4;
    logic [3:0]  src_offset = 4'd0;
    logic [63:0] win_start = 64'd0;
    logic [15:0] seq_per_buf = 16'd1;
    logic [1:0]  buf_count = 2'd0;
    logic [47:0] class_cnt[3];
    logic [47:0] class_bytes[3];
    logic [47:0] late_cnt[16], late_bytes[16], valid_cnt[16], valid_bytes[16];

    function new();
      foreach (class_cnt[i]) begin
        class_cnt[i] = '0;
        class_bytes[i] = '0;
      end
      foreach (late_cnt[i]) begin
        late_cnt[i] = '0;
        late_bytes[i] = '0;
        valid_cnt[i] = '0;
        valid_bytes[i] = '0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_SRC_COUNT: src_count = v[4:0];
        REG_SRC_OFFSET: src_offset = v[3:0];
        REG_WIN_START: win_start = v;
        REG_SEQ_PER_BUF: seq_per_buf = v[15:0];
        REG_BUF_COUNT: buf_count = v[1:0];
        default: ;
      endcase
    endfunction

    function void note_request(header_t h);
      verdict_rec_t r;
      int src;
      bit ok;
      logic [63:0] seq, nb, wend, d, idx, inner, off, spb, gap;
      logic [12:0] pay;
      r = '{V_INVALID, 0, 0, 0, 0, 0, 0, 0, 0};
      src = (int'(h.fid[5:3]) - 1) * 2 + int'(h.fid[7]) - int'(src_offset);
      ok = h.fb >= HDR_BYTES && h.fb <= MAX_FRAME_B && h.sync == SYNC_VALUE &&
           h.dec != 0 && !h.tw[31] && src >= 0 && src < int'(src_count) && src < 16;
      if (!ok) begin
        class_cnt[0] += 1;
        class_bytes[0] += h.fb;
        r.cnt = class_cnt[0];
      end else begin
        spb = seq_per_buf;
        r.tt = h.raw - h.toff;
        seq = r.tt / h.dec / 64'd4096;
        pay = h.fb - HDR_BYTES;
        nb = (buf_count > 2) ? 2 : buf_count;
        wend = win_start + nb * spb;
        d = seq - win_start;
        gap = seq - wend;
        r.src = src[3:0];
        r.seq = seq;
        r.pay = pay;
        if (!gap[63]) begin
          r.verdict = V_BEYOND;
        end else if (d[63]) begin
          r.verdict = V_LATE;
          class_cnt[1] += 1;
          class_bytes[1] += pay;
          late_cnt[src] += 1;
          late_bytes[src] += pay;
          r.cnt = class_cnt[1];
        end else begin
          idx = (d >= spb ? 1 : 0) + (d >= 2 * spb ? 1 : 0);
          inner = d - idx * spb;
          off = inner * src_count * pay;
          if (off > 64'hFFFF_FFFF) off = 64'hFFFF_FFFF;
          r.verdict = V_ACCEPT;
          class_cnt[2] += 1;
          class_bytes[2] += pay;
          valid_cnt[src] += 1;
          valid_bytes[src] += pay;
          r.tuning = h.tw[30:0];
          r.bidx = idx[0];
          r.eoff = off[31:0];
          r.cnt = class_cnt[2];
        end
      end
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(verdict_rec_t a);
      verdict_rec_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("verdict", e.verdict, a.verdict);
      cmp("source_index", e.src, a.src);
      cmp("sequence_res", e.seq, a.seq);
      cmp("corr_tag", e.tt, a.tt);
      cmp("tuning", e.tuning, a.tuning);
      cmp("buffer_index", e.bidx, a.bidx);
      cmp("element_offset", e.eoff, a.eoff);
      cmp("payload_bytes", e.pay, a.pay);
      cmp("class_count", e.cnt, a.cnt);
    endfunction
  endclass

  logic clk = 0, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [31:0] in_sync_pattern, in_tuning_word;
  logic [7:0]  in_frame_id;
  logic [15:0] in_decimation, in_time_offset;
  logic [63:0] in_raw_time_tag;
  logic [12:0] in_frame_bytes;
  logic [1:0]  out_verdict;
  logic [3:0]  out_source_index;
  logic [63:0] out_sequence_res, out_corr_tag;
  logic [30:0] out_tuning;
  logic        out_buffer_index;
  logic [31:0] out_element_offset;
  logic [12:0] out_payload_bytes;
  logic [47:0] out_class_count;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;

  frame_scoreboard sb = new();
  bit quiet = 0;
  int stall_left = 0;

  radio_frame_header_classifier dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{verdict_t'(out_verdict), out_source_index, out_sequence_res,
                        out_corr_tag, out_tuning, out_buffer_index, out_element_offset,
                        out_payload_bytes, out_class_count});
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_stall <= stall_left > 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_frame(header_t h);
    int gap;
    in_valid <= 1'b1;
    in_sync_pattern <= h.sync;
    in_frame_id <= h.fid;
    in_decimation <= h.dec;
    in_time_offset <= h.toff;
    in_raw_time_tag <= h.raw;
    in_tuning_word <= h.tw;
    in_frame_bytes <= h.fb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(h);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [4:0] sc, logic [3:0] so, logic [63:0] ws,
                           logic [15:0] spb, logic [1:0] bc);
    cfg_write(REG_SRC_COUNT, {$urandom, $urandom} & ~64'h1F | sc);
    cfg_write(REG_SRC_OFFSET, so);
    cfg_write(REG_WIN_START, ws);
    cfg_write(REG_SEQ_PER_BUF, spb);
    cfg_write(REG_BUF_COUNT, bc);
  endtask

  // well-formed header aimed at a given sequence number and source id
  function automatic header_t good_frame(logic [63:0] seq, int sid, logic [15:0] dec);
    header_t h;
    int tune;
    tune = (sid / 2) + 1;
    if (tune > 7) tune = 7;
    h.sync = SYNC_VALUE;
    h.fid = {sid[0], 1'($urandom), 3'(tune), 3'($urandom)};
    h.dec = dec;
    h.toff = 16'($urandom);
    h.raw = seq * dec * 64'd4096 + $urandom_range(0, dec * 4096 - 1) + h.toff;
    h.tw = $urandom & 32'h7FFF_FFFF;
    h.fb = 13'($urandom_range(32, 4128));
    return h;
  endfunction

  function automatic header_t noise_frame();
    header_t h;
    h.sync = $urandom_range(0, 1) ? SYNC_VALUE : $urandom;
    h.fid = 8'($urandom);
    h.dec = $urandom_range(0, 7) == 0 ? 16'd0 : 16'($urandom);
    h.toff = 16'($urandom);
    h.raw = {$urandom, $urandom};
    h.tw = $urandom;
    h.fb = 13'($urandom);
    return h;
  endfunction

  task automatic random_phase(int n);
    header_t h;
    logic [63:0] seq;
    int span;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        span = int'(sb.seq_per_buf) * 2 + 4;
        seq = sb.win_start + 64'($urandom_range(0, span)) - sb.seq_per_buf - 2;
        h = good_frame(seq, $urandom_range(0, 13) + sb.src_offset,
                       $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 65535)) : 16'd1);
        if ($urandom_range(0, 19) == 0) h.fb = $urandom_range(0, 1) ? 13'd32 : 13'd4128;
      end else begin
        h = noise_frame();
      end
      push_frame(h);
    end
    drain();
  endtask

  initial begin
    header_t h;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sync_pattern <= '0;
    in_frame_id <= '0;
    in_decimation <= '0;
    in_time_offset <= '0;
    in_raw_time_tag <= '0;
    in_tuning_word <= '0;
    in_frame_bytes <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no buffer open, everything valid is beyond
    push_frame(good_frame(64'd0, 1, 16'd1));
    drain();

    configure(5'd16, 4'd0, 64'd1000, 16'd8, 2'd2);
    h = good_frame(64'd1000, 2, 16'd1); h.sync = 32'h5CDEC0DF; push_frame(h);
    h = good_frame(64'd1000, 2, 16'd1); h.fb = 13'd31; push_frame(h);
    h = good_frame(64'd1000, 2, 16'd1); h.fb = 13'd4129; push_frame(h);
    h = good_frame(64'd1000, 2, 16'd1); h.fb = 13'h1FFF; push_frame(h);
    h = good_frame(64'd1000, 2, 16'd1); h.dec = 16'd0; push_frame(h);
    h = good_frame(64'd1000, 2, 16'd1); h.tw[31] = 1'b1; push_frame(h);
    h = good_frame(64'd1000, 2, 16'd1); h.fid[5:3] = 3'd0; push_frame(h);
    push_frame(good_frame(64'd999, 0, 16'd1));
    push_frame(good_frame(64'd1000, 13, 16'd1));
    push_frame(good_frame(64'd1007, 5, 16'd1));
    push_frame(good_frame(64'd1008, 6, 16'd1));
    push_frame(good_frame(64'd1015, 7, 16'd1));
    push_frame(good_frame(64'd1016, 3, 16'd1));
    h = good_frame(64'd1003, 4, 16'd1); h.fb = 13'd32; push_frame(h);
    h = good_frame(64'd1003, 4, 16'd1); h.fb = 13'd4128; h.tw = 32'h7FFF_FFFF; push_frame(h);
    h = good_frame(64'd1, 1, 16'd1); h.raw = 64'd5; h.toff = 16'hFFFF; push_frame(h);
    h = good_frame(64'd1, 1, 16'hFFFF); h.raw = '1; push_frame(h);
    drain();

    random_phase(160);
    configure(5'd1, 4'd15, 64'd20, 16'd3, 2'd1);
    random_phase(120);
    configure(5'd31, 4'd3, 64'd500, 16'd65535, 2'd3);
    random_phase(140);
    quiet = 1;
    configure(5'd5, 4'd1, 64'hFFFF_FFFF_FFFF_FFF0, 16'd20, 2'd2);
    random_phase(120);
    quiet = 0;
    configure(5'd9, 4'd2, 64'd300, 16'd0, 2'd2);
    random_phase(100);
    configure(5'd16, 4'd0, {$urandom, $urandom} >> 12, 16'd6, 2'd2);
    random_phase(160);
    configure(5'd12, 4'd4, 64'd0, 16'd1, 2'd0);
    random_phase(100);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ radio_frame_header_classifier.f @@
hdl/rfhc_pkg.sv
hdl/rfhc_div.sv
hdl/rfhc_counters.sv
hdl/radio_frame_header_classifier.sv
tb/tb_radio_frame_header_classifier.sv
